/* rtl/bias_pkg.sv */
// Shared constants and lookup functions for the affine block-index shuffle.
// No dependencies; used by every module of the block.
package bias_pkg;

  localparam int INDEX_BITS_DEF = 32;   // default index width
  localparam int FIELD_BITS     = 32;   // port width of index fields
  localparam int SEED_BITS      = 64;   // grid id and seed width
  localparam int HASH_BITS      = 64;   // width of a mixed hash
  localparam int MOD_STEPS      = 2;    // remainder bits resolved per divider stage
  localparam int FIFO_DEPTH     = 4;    // queue between front and back
  localparam int PRIME_BITS     = 5;    // width of a table prime

  localparam logic [63:0] SALT_A = 64'h243f6a8885a308d3;
  localparam logic [63:0] SALT_B = 64'h13198a2e03707344;

  localparam logic [31:0] MIX_C1_LO = 32'h1ce4e5b9;
  localparam logic [31:0] MIX_C1_HI = 32'hbf58476d;
  localparam logic [31:0] MIX_C2_LO = 32'h133111eb;
  localparam logic [31:0] MIX_C2_HI = 32'h94d049bb;

  localparam int MIX_SH1 = 30;
  localparam int MIX_SH2 = 27;
  localparam int MIX_SH3 = 31;

  // Table prime picked by the low hash bits
  function automatic logic [PRIME_BITS-1:0] prime_of(input logic [2:0] sel);
    logic [PRIME_BITS-1:0] p;
    case (sel)
      3'd0:    p = 5'd3;
      3'd1:    p = 5'd5;
      3'd2:    p = 5'd7;
      3'd3:    p = 5'd11;
      3'd4:    p = 5'd13;
      3'd5:    p = 5'd17;
      3'd6:    p = 5'd19;
      default: p = 5'd23;
    endcase
    return p;
  endfunction

  // Multiplicative inverse of the prime modulo 2^32
  function automatic logic [31:0] inv_of(input logic [2:0] sel);
    logic [31:0] v;
    case (sel)
      3'd0:    v = 32'haaaaaaab;
      3'd1:    v = 32'hcccccccd;
      3'd2:    v = 32'hb6db6db7;
      3'd3:    v = 32'hba2e8ba3;
      3'd4:    v = 32'hc4ec4ec5;
      3'd5:    v = 32'hf0f0f0f1;
      3'd6:    v = 32'h286bca1b;
      default: v = 32'he9bd37a7;
    endcase
    return v;
  endfunction

  // Largest multiple index: (2^32-1) / prime
  function automatic logic [31:0] lim_of(input logic [2:0] sel);
    logic [31:0] v;
    case (sel)
      3'd0:    v = 32'h55555555;
      3'd1:    v = 32'h33333333;
      3'd2:    v = 32'h24924924;
      3'd3:    v = 32'h1745d174;
      3'd4:    v = 32'h13b13b13;
      3'd5:    v = 32'h0f0f0f0f;
      3'd6:    v = 32'h0d79435e;
      default: v = 32'h0b21642c;
    endcase
    return v;
  endfunction

endpackage

/* rtl/bias_front.sv */
// Front pipeline: accepts items, hashes the seed, picks the multiplier, forms a*x.
// Depends on bias_pkg.
module bias_front #(
  parameter int INDEX_BITS = bias_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [INDEX_BITS-1:0]           x_in,
  input  logic [INDEX_BITS-1:0]           n_in,
  input  logic [bias_pkg::SEED_BITS-1:0]  seed_in,
  input  logic                            fifo_full,
  output logic                            push,
  output logic                            byp_out,
  output logic [INDEX_BITS-1:0]           x_out,
  output logic [INDEX_BITS-1:0]           n_out,
  output logic [2*INDEX_BITS-1:0]         prod_out,
  output logic [bias_pkg::HASH_BITS-1:0]  hb_out
);

  localparam int NST = 8;
  localparam int HB  = bias_pkg::HASH_BITS;

  logic                  vld   [NST];
  logic                  byp   [NST];
  logic [INDEX_BITS-1:0] xq    [NST];
  logic [INDEX_BITS-1:0] nq    [NST];
  logic [HB-1:0]         seed0;
  logic [HB-1:0]         pl0   [2];
  logic [31:0]           pl1   [2];
  logic [31:0]           pl2   [2];
  logic [HB-1:0]         h2    [2];
  logic [HB-1:0]         ql0   [2];
  logic [31:0]           ql1   [2];
  logic [31:0]           ql2   [2];
  logic [HB-1:0]         h4    [2];
  logic [31:0]           chk5;
  logic [31:0]           lim5;
  logic [bias_pkg::PRIME_BITS-1:0] p5;
  logic [HB-1:0]         hb5;
  logic [INDEX_BITS-1:0] mult6;
  logic [HB-1:0]         hb6;
  logic [2*INDEX_BITS-1:0] prod7;
  logic [HB-1:0]         hb7;
  logic                  en;

  logic [HB-1:0] a1 [2];
  logic [HB-1:0] m2 [2];
  logic [HB-1:0] m4 [2];
  logic [63:0]   pp0 [2];
  logic [63:0]   qp0 [2];

  assign en       = !(vld[NST-1] && fifo_full);
  assign in_ready = en;
  assign push     = vld[NST-1] && !fifo_full;
  assign byp_out  = byp[NST-1];
  assign x_out    = xq[NST-1];
  assign n_out    = nq[NST-1];
  assign prod_out = prod7;
  assign hb_out   = hb7;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a1[l]  = ((l == 0) ? (seed0 ^ bias_pkg::SALT_A) : (seed0 ^ bias_pkg::SALT_B));
      a1[l]  = a1[l] ^ (a1[l] >> bias_pkg::MIX_SH1);
      pp0[l] = a1[l][31:0] * bias_pkg::MIX_C1_LO;
      m2[l]  = pl0[l] + {pl1[l] + pl2[l], 32'h0};
      qp0[l] = h2[l][31:0] * bias_pkg::MIX_C2_LO;
      m4[l]  = ql0[l] + {ql1[l] + ql2[l], 32'h0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // capture and classify
      xq[0]  <= x_in;
      nq[0]  <= n_in;
      byp[0] <= (n_in <= INDEX_BITS'(1));
      seed0  <= seed_in;
      for (int s = 1; s < NST; s++) begin
        xq[s]  <= xq[s-1];
        nq[s]  <= nq[s-1];
        byp[s] <= byp[s-1];
      end
      for (int l = 0; l < 2; l++) begin
        // first multiply, split into 32-bit partial products
        pl0[l] <= pp0[l];
        pl1[l] <= a1[l][63:32] * bias_pkg::MIX_C1_LO;
        pl2[l] <= a1[l][31:0] * bias_pkg::MIX_C1_HI;
        h2[l]  <= m2[l] ^ (m2[l] >> bias_pkg::MIX_SH2);
        // second multiply
        ql0[l] <= qp0[l];
        ql1[l] <= h2[l][63:32] * bias_pkg::MIX_C2_LO;
        ql2[l] <= h2[l][31:0] * bias_pkg::MIX_C2_HI;
        h4[l]  <= m4[l] ^ (m4[l] >> bias_pkg::MIX_SH3);
      end
      // divisibility test by the chosen prime: n * inv <= limit
      chk5  <= 32'(nq[4]) * bias_pkg::inv_of(h4[0][2:0]);
      lim5  <= bias_pkg::lim_of(h4[0][2:0]);
      p5    <= bias_pkg::prime_of(h4[0][2:0]);
      hb5   <= h4[1];
      mult6 <= (chk5 <= lim5) ? (nq[5] - INDEX_BITS'(1)) : INDEX_BITS'(p5);
      hb6   <= hb5;
      prod7 <= (2*INDEX_BITS)'(mult6) * (2*INDEX_BITS)'(xq[6]);
      hb7   <= hb6;
    end
  end

endmodule

/* rtl/bias_fifo.sv */
// Short queue between the front and back pipelines.
// Depends on bias_pkg for the default depth.
module bias_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = bias_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/bias_mod.sv */
// Pipelined remainder unit: several lanes share one divisor, MOD_STEPS bits per stage.
// Depends on bias_pkg for the step count.
module bias_mod #(
  parameter int DIVIDEND_BITS = bias_pkg::HASH_BITS,
  parameter int DIVISOR_BITS  = bias_pkg::INDEX_BITS_DEF,
  parameter int LANES         = 2
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [DIVIDEND_BITS-1:0] dividend [LANES],
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic [DIVISOR_BITS-1:0]  rem      [LANES]
);

  localparam int STEPS  = bias_pkg::MOD_STEPS;
  localparam int STAGES = DIVIDEND_BITS / STEPS;

  logic [DIVISOR_BITS-1:0]  rem_q [STAGES][LANES];
  logic [DIVIDEND_BITS-1:0] dvd_q [STAGES][LANES];
  logic [DIVISOR_BITS-1:0]  div_q [STAGES];
  logic [DIVISOR_BITS-1:0]  rem_n [STAGES][LANES];
  logic [DIVIDEND_BITS-1:0] dvd_n [STAGES][LANES];

  always_comb begin
    logic [DIVISOR_BITS-1:0]  r;
    logic [DIVIDEND_BITS-1:0] d;
    logic [DIVISOR_BITS:0]    t;
    logic [DIVISOR_BITS-1:0]  dv;
    for (int s = 0; s < STAGES; s++) begin
      dv = (s == 0) ? divisor : div_q[(s == 0) ? 0 : s - 1];
      for (int l = 0; l < LANES; l++) begin
        r = (s == 0) ? '0 : rem_q[(s == 0) ? 0 : s - 1][l];
        d = (s == 0) ? dividend[l] : dvd_q[(s == 0) ? 0 : s - 1][l];
        for (int j = 0; j < STEPS; j++) begin
          // shift in the next dividend bit, subtract when it fits
          t = {r, d[DIVIDEND_BITS-1]};
          d = d << 1;
          if (t >= {1'b0, dv}) begin
            t = t - {1'b0, dv};
          end
          r = t[DIVISOR_BITS-1:0];
        end
        rem_n[s][l] = r;
        dvd_n[s][l] = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_q[0] <= divisor;
      for (int s = 1; s < STAGES; s++) begin
        div_q[s] <= div_q[s-1];
      end
      for (int s = 0; s < STAGES; s++) begin
        for (int l = 0; l < LANES; l++) begin
          rem_q[s][l] <= rem_n[s][l];
          dvd_q[s][l] <= dvd_n[s][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[l] = rem_q[STAGES-1][l];
    end
  end

endmodule

/* rtl/bias_back.sv */
// Back pipeline: two remainders modulo N, final add and reduce, output register.
// Depends on bias_pkg and bias_mod.
module bias_back #(
  parameter int INDEX_BITS = bias_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            fifo_empty,
  output logic                            pop,
  input  logic                            byp_in,
  input  logic [INDEX_BITS-1:0]           x_in,
  input  logic [INDEX_BITS-1:0]           n_in,
  input  logic [2*INDEX_BITS-1:0]         prod_in,
  input  logic [bias_pkg::HASH_BITS-1:0]  hb_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bias_pkg::FIELD_BITS-1:0] logical_index
);

  localparam int HB     = bias_pkg::HASH_BITS;
  localparam int STAGES = HB / bias_pkg::MOD_STEPS;

  logic                  vld [STAGES];
  logic                  byp [STAGES];
  logic [INDEX_BITS-1:0] xq  [STAGES];
  logic [INDEX_BITS-1:0] nq  [STAGES];
  logic [HB-1:0]         dvd [2];
  logic [INDEX_BITS-1:0] rem [2];
  logic [INDEX_BITS:0]   sum;
  logic [INDEX_BITS:0]   red;
  logic                  en;

  assign en     = !out_valid || out_ready;
  assign pop    = en && !fifo_empty;
  assign dvd[0] = hb_in;
  assign dvd[1] = HB'(prod_in);

  bias_mod #(
    .DIVIDEND_BITS (HB),
    .DIVISOR_BITS  (INDEX_BITS),
    .LANES         (2)
  ) u_mod (
    .clk      (clk),
    .en       (en),
    .dividend (dvd),
    .divisor  (n_in),
    .rem      (rem)
  );

  // (a*x mod N) + (hash_b mod N) stays below 2N: one subtract reduces it
  always_comb begin
    sum = (INDEX_BITS+1)'(rem[0]) + (INDEX_BITS+1)'(rem[1]);
    red = (sum >= {1'b0, nq[STAGES-1]}) ? (sum - {1'b0, nq[STAGES-1]}) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        vld[s] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= pop;
      for (int s = 1; s < STAGES; s++) begin
        vld[s] <= vld[s-1];
      end
      out_valid <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xq[0]  <= x_in;
      nq[0]  <= n_in;
      byp[0] <= byp_in;
      for (int s = 1; s < STAGES; s++) begin
        xq[s]  <= xq[s-1];
        nq[s]  <= nq[s-1];
        byp[s] <= byp[s-1];
      end
      logical_index <= byp[STAGES-1] ? bias_pkg::FIELD_BITS'(xq[STAGES-1])
                                     : bias_pkg::FIELD_BITS'(red[INDEX_BITS-1:0]);
    end
  end

endmodule

/* rtl/block_index_affine_shuffle.sv */
// Top level of the affine block-index shuffle: seed register, front, queue, back.
// Depends on bias_pkg, bias_front, bias_fifo, bias_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  in       | in_valid / in_ready    | physical_index, grid_size, grid_id
//  out      | out_valid / out_ready  | logical_index
//  config   | cfg_we                 | shuffle_seed (64 bits, no read-back)
//
// One transaction per clock is sustained in both directions while out_ready stays
// high. Data pass the front (two SplitMix64 multiplies as 32-bit partial products,
// prime test, a*x), the queue, the remainder pipeline (two bits of the 64-bit
// dividend per stage) and one output register.
// rst is synchronous and clears all valid flags, the queue and the seed.
// A stall at out_ready freezes the back; the queue then absorbs the front
// until it fills; in_ready then drops once the front's last stage holds an item.
module block_index_affine_shuffle #(
  parameter int INDEX_BITS = bias_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [bias_pkg::FIELD_BITS-1:0] physical_index,
  input  logic [bias_pkg::FIELD_BITS-1:0] grid_size,
  input  logic [bias_pkg::SEED_BITS-1:0]  grid_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bias_pkg::FIELD_BITS-1:0] logical_index,
  input  logic                            cfg_we,
  input  logic [bias_pkg::SEED_BITS-1:0]  shuffle_seed
);

  localparam int HB = bias_pkg::HASH_BITS;
  // queue entry: bypass, x, n, a*x, hash_b
  localparam int QW = 1 + 4 * INDEX_BITS + HB;

  logic [bias_pkg::SEED_BITS-1:0] seed;
  logic                  f_push;
  logic                  f_byp;
  logic [INDEX_BITS-1:0] f_x;
  logic [INDEX_BITS-1:0] f_n;
  logic [2*INDEX_BITS-1:0] f_prod;
  logic [HB-1:0]         f_hb;
  logic [QW-1:0]         q_wdata;
  logic [QW-1:0]         q_rdata;
  logic                  q_full;
  logic                  q_empty;
  logic                  b_pop;

  // hold the software seed; the user must write it only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_we) begin
      seed <= shuffle_seed;
    end
  end

  bias_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_in      (physical_index[INDEX_BITS-1:0]),
    .n_in      (grid_size[INDEX_BITS-1:0]),
    .seed_in   (grid_id ^ seed),
    .fifo_full (q_full),
    .push      (f_push),
    .byp_out   (f_byp),
    .x_out     (f_x),
    .n_out     (f_n),
    .prod_out  (f_prod),
    .hb_out    (f_hb)
  );

  assign q_wdata = {f_byp, f_x, f_n, f_prod, f_hb};

  bias_fifo #(
    .WIDTH (QW),
    .DEPTH (bias_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_push),
    .wr_data (q_wdata),
    .rd_en   (b_pop),
    .rd_data (q_rdata),
    .full    (q_full),
    .empty   (q_empty)
  );

  bias_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .fifo_empty    (q_empty),
    .pop           (b_pop),
    .byp_in        (q_rdata[QW-1]),
    .x_in          (q_rdata[QW-2 -: INDEX_BITS]),
    .n_in          (q_rdata[QW-2-INDEX_BITS -: INDEX_BITS]),
    .prod_in       (q_rdata[HB +: 2*INDEX_BITS]),
    .hb_in         (q_rdata[HB-1:0]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .logical_index (logical_index)
  );

endmodule

/* test/block_index_affine_shuffle_test.sv */
// Testbench for the affine block-index shuffle: directed and random transactions
// checked against a behavioural predictor. Depends on bias_pkg and the RTL top.
`timescale 1ns / 1ps

module block_index_affine_shuffle_test;

  localparam int  LATENCY     = 42;
  localparam int  MAX_GAP     = 18;
  localparam int  LONG_HOLD   = 300;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] physical_index = '0;
  logic [31:0] grid_size = '0;
  logic [63:0] grid_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] logical_index;
  logic        cfg_we = 1'b0;
  logic [63:0] shuffle_seed = '0;

  // Predictor state: the seed register as last written
  logic [63:0] seed_reg = '0;
  logic [31:0] index_queue[$];
  int          error_count = 0;
  longint      cycle_count = 0;
  bit          hold_off = 1'b0;   // long receiver stall requested
  bit          quiet = 1'b0;      // no random stalls on either side

  always #2 clk = ~clk;

  block_index_affine_shuffle u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .physical_index(physical_index), .grid_size(grid_size), .grid_id(grid_id),
    .out_valid(out_valid), .out_ready(out_ready), .logical_index(logical_index),
    .cfg_we(cfg_we), .shuffle_seed(shuffle_seed)
  );

  function automatic logic [63:0] splitmix_final(input logic [63:0] v);
    logic [63:0] h;
    h = v ^ (v >> 30);
    h = h * 64'hbf58476d1ce4e5b9;
    h = h ^ (h >> 27);
    h = h * 64'h94d049bb133111eb;
    return h ^ (h >> 31);
  endfunction

  // Work out the logical index the block should produce
  function automatic logic [31:0] shuffled_index(input logic [31:0] x, input logic [31:0] n,
                                                 input logic [63:0] gid);
    logic [63:0] s, ha, hb, mult, offs;
    logic [63:0] primes [8];
    primes = '{64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19, 64'd23};
    if (n <= 32'd1) return x;
    s    = gid ^ seed_reg;
    ha   = splitmix_final(s ^ bias_pkg::SALT_A);
    hb   = splitmix_final(s ^ bias_pkg::SALT_B);
    mult = primes[ha[2:0]];
    if ({32'd0, n} % mult == 64'd0) mult = {32'd0, n} - 64'd1;
    offs = hb % {32'd0, n};
    return 32'((mult * {32'd0, x} + offs) % {32'd0, n});
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("block_index_affine_shuffle_test NOT OK");
      $finish;
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (index_queue.size() == 0) begin
        $display("%0t: unexpected logical_index %h", $time, logical_index);
        error_count++;
      end else begin
        if (index_queue[0] !== logical_index) begin
          $display("%0t: logical_index expected %h actual %h",
                   $time, index_queue[0], logical_index);
          error_count++;
        end
        void'(index_queue.pop_front());
      end
    end
  end

  // Receiver: random stalls, or hold ready low for a long stretch on request
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off = 1'b0;
      end
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Send one transaction after a random gap; expectation is queued on acceptance
  task automatic send_item(input logic [31:0] x, input logic [31:0] n, input logic [63:0] gid);
    int gap;
    gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    physical_index <= x;
    grid_size <= n;
    grid_id <= gid;
    do @(posedge clk); while (!in_ready);
    index_queue = {index_queue, shuffled_index(x, n, gid)};
    @(negedge clk);
  endtask

  // Drain everything, let the pipeline settle, then write the seed
  task automatic write_seed(input logic [63:0] value);
    in_valid <= 1'b0;
    while (index_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    shuffle_seed <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_reg = value;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_item(32'd0, 32'd0, 64'd0);
    send_item(32'hffffffff, 32'd0, 64'hffffffffffffffff);
    send_item(32'hffffffff, 32'd1, 64'd7);
    send_item(32'd5, 32'd2, 64'd0);
    send_item(32'hffffffff, 32'hffffffff, 64'hffffffffffffffff);
    send_item(32'hfffffffe, 32'hffffffff, 64'd0);
    send_item(32'd100, 32'd10, 64'd3);         // index beyond the grid
    send_item(32'hffffffff, 32'd2, 64'h5555);
    // Grids that are multiples of every table prime force the N-1 multiplier
    for (int i = 0; i < 8; i++)
      send_item(32'(i * 1000), 32'd111546435, 64'(i * 17));
    for (int i = 0; i < 6; i++)
      send_item($urandom(), 32'd223092870, rand64());
  endtask

  task automatic test_seeds();
    logic [63:0] seeds [4];
    seeds = '{64'hffffffffffffffff, 64'h0000000000000001, 64'h8000000000000000, 64'd0};
    foreach (seeds[k]) begin
      write_seed(seeds[k]);
      for (int i = 0; i < 30; i++) send_item($urandom(), $urandom_range(0, 40), rand64());
    end
  endtask

  task automatic test_random(input int count);
    logic [31:0] n;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 4))
        0: n = $urandom_range(0, 3);
        1: n = $urandom_range(2, 300);
        2: n = 32'($urandom_range(1, 30)) * 32'd111546435;
        default: n = $urandom();
      endcase
      send_item(($urandom_range(0, 1) && n > 1) ? $urandom() % n : $urandom(), n, rand64());
      if (i % 400 == 399) write_seed(rand64());
    end
  endtask

  // Stop the receiver for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    write_seed(rand64());
    quiet = 1'b1;
    hold_off = 1'b1;
    for (int i = 0; i < 120; i++) send_item($urandom(), $urandom(), rand64());
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_seeds();
    test_backpressure();
    test_random(1600);
    in_valid <= 1'b0;
    while (index_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (error_count == 0) begin
      $display("block_index_affine_shuffle_test OK");
    end else begin
      $display("block_index_affine_shuffle_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bias_pkg.sv
rtl/bias_front.sv
rtl/bias_fifo.sv
rtl/bias_mod.sv
rtl/bias_back.sv
rtl/block_index_affine_shuffle.sv
test/block_index_affine_shuffle_test.sv
